/* sv/login_lockout_table_defines.svh */
// Assertion macros shared by the login lockout table RTL.
`ifndef LOGIN_LOCKOUT_TABLE_DEFINES_SVH
`define LOGIN_LOCKOUT_TABLE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/llt_pkg.sv */
// Types, constants and codes for the login lockout table.
package llt_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int KEY_W   = 32;
   localparam int TIME_W  = 32;
   localparam int FAIL_W  = 8;
   localparam int MAXF_W  = 8;
   localparam int BLOCK_W = 31;
   localparam int STAT_W  = 3;
   localparam int RETRY_W = 22;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
   localparam int RECIP_W     = 29;
   localparam int PROD_W      = TIME_W + RECIP_W;
   localparam int RECIP_SHIFT = 38;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h10624DD3;
   localparam logic [TIME_W-1:0]  ROUND_UP   = 32'd999;

   localparam logic [FAIL_W-1:0]  FAIL_SAT       = 8'd255;
   localparam logic [MAXF_W-1:0]  MAXF_RESET     = 8'd5;
   localparam logic [BLOCK_W-1:0] BLOCK_MS_RESET = 31'd60000;

   // register index = paddr bit 2
   localparam logic CSR_MAX_FAILURES = 1'b0;
   localparam logic CSR_BLOCK_MS     = 1'b1;

   localparam logic MODE_ATTEMPT = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_GRANTED    = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_LOCKED     = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_BAD        = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_BAD_LOCKED = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_CLEARED    = 3'd4;

   typedef struct packed {
      logic              mode;
      logic [KEY_W-1:0]  client_key;
      logic [TIME_W-1:0] now_ms;
      logic              password_ok;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [RETRY_W-1:0] retry_after_s;
   } rsp_type;

   typedef struct packed {
      logic [MAXF_W-1:0]  max_failures;
      logic [BLOCK_W-1:0] block_ms;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] last_seen;
      logic [FAIL_W-1:0] fail_count;
      logic [TIME_W-1:0] blocked_until;
   } slot_type;

   // controller -> datapath
   typedef struct packed {
      logic             load;
      logic             clear;
      logic             step;
      logic             eval;
      logic             finish;
      logic [IDX_W-1:0] idx;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
   } ctl_stat_type;

endpackage

/* sv/llt_csr.sv */
// Configuration registers behind the APB-style port.
module llt_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [llt_pkg::CSR_AW-1:0]   paddr,
   input  logic [llt_pkg::CSR_DW-1:0]   pwdata,
   output logic [llt_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   output llt_pkg::cfg_type             cfg
);

   logic [llt_pkg::MAXF_W-1:0]  max_failures_ff;
   logic [llt_pkg::BLOCK_W-1:0] block_ms_ff;
   logic                        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_failures_ff <= llt_pkg::MAXF_RESET;
         block_ms_ff     <= llt_pkg::BLOCK_MS_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            llt_pkg::CSR_MAX_FAILURES: max_failures_ff <= pwdata[llt_pkg::MAXF_W-1:0];
            llt_pkg::CSR_BLOCK_MS:     block_ms_ff     <= pwdata[llt_pkg::BLOCK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         llt_pkg::CSR_MAX_FAILURES:
            prdata = {{(llt_pkg::CSR_DW-llt_pkg::MAXF_W){1'b0}}, max_failures_ff};
         llt_pkg::CSR_BLOCK_MS:
            prdata = {{(llt_pkg::CSR_DW-llt_pkg::BLOCK_W){1'b0}}, block_ms_ff};
         default:
            prdata = '0;
      endcase
   end

   assign cfg.max_failures = max_failures_ff;
   assign cfg.block_ms     = block_ms_ff;

endmodule

/* sv/llt_ctrl.sv */
// Sequencer: an attempt scans the slots one per cycle up to a key match or the last slot, then evaluates and finishes.
`include "login_lockout_table_defines.svh"

module llt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   mode,
   output logic                   busy,
   input  llt_pkg::ctl_stat_type  stat,
   output llt_pkg::ctl_cmd_type   cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EVAL, ST_MUL} state_type;

   state_type                 state_ff;
   logic [llt_pkg::IDX_W-1:0] idx_ff;
   logic                      accept;
   logic                      last;

   assign accept = start & (state_ff == ST_IDLE);
   assign last   = (idx_ff == llt_pkg::IDX_W'(llt_pkg::SLOT_COUNT - 1));
   assign busy   = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (accept && mode == llt_pkg::MODE_ATTEMPT) state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (stat.hit || last) begin
                  state_ff <= ST_EVAL;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_EVAL: state_ff <= ST_MUL;
            ST_MUL:  state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign cmd.load   = accept & (mode == llt_pkg::MODE_ATTEMPT);
   assign cmd.clear  = accept & (mode == llt_pkg::MODE_CLEAR);
   assign cmd.step   = (state_ff == ST_SCAN);
   assign cmd.eval   = (state_ff == ST_EVAL);
   assign cmd.finish = (state_ff == ST_MUL);
   assign cmd.idx    = idx_ff;

   `LLT_ASSERT_NEXT(a_scan_ends, (state_ff == ST_SCAN) && (stat.hit || last), state_ff == ST_EVAL, "scan did not end on hit or last slot")
   `LLT_ASSERT_NEXT(a_eval_to_mul, state_ff == ST_EVAL, state_ff == ST_MUL, "eval not followed by finish")
   `LLT_ASSERT_NEXT(a_scan_from_zero, cmd.load, (state_ff == ST_SCAN) && (idx_ff == '0), "scan did not start at slot zero")

endmodule

/* sv/llt_dp.sv */
// Slot table, scan pick logic, lockout evaluation and the /1000 multiplier.
`include "login_lockout_table_defines.svh"

module llt_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  llt_pkg::req_type       req_word,
   input  llt_pkg::cfg_type       cfg,
   input  llt_pkg::ctl_cmd_type   cmd,
   output llt_pkg::ctl_stat_type  stat,
   output logic                   rsp_strobe,
   output llt_pkg::rsp_type       rsp_word
);

   llt_pkg::slot_type table_ff [llt_pkg::SLOT_COUNT];

   logic [llt_pkg::KEY_W-1:0]   key_ff;
   logic [llt_pkg::TIME_W-1:0]  now_ff;
   logic                        ok_ff;
   logic [llt_pkg::IDX_W-1:0]   pick_ff;
   logic [llt_pkg::TIME_W-1:0]  pick_ls_ff;
   logic [llt_pkg::IDX_W-1:0]   sel_ff;
   logic                        found_ff;
   logic [llt_pkg::TIME_W-1:0]  num_ff;
   logic [llt_pkg::STAT_W-1:0]  status_ff;
   logic                        strobe_ff;
   llt_pkg::rsp_type            rsp_ff;

   logic [llt_pkg::IDX_W-1:0]   rd_addr;
   llt_pkg::slot_type           rd;
   logic                        hit;
   logic                        take;
   logic [llt_pkg::IDX_W-1:0]   pick_in;
   logic [llt_pkg::TIME_W-1:0]  pick_ls_in;

   llt_pkg::slot_type           ent;
   llt_pkg::slot_type           wr;
   logic                        blocked;
   logic [llt_pkg::TIME_W-1:0]  diff;
   logic                        locked;
   logic [llt_pkg::FAIL_W-1:0]  fc_base;
   logic [llt_pkg::FAIL_W-1:0]  fc_inc;
   logic [llt_pkg::TIME_W-1:0]  block_ext;
   logic [llt_pkg::TIME_W-1:0]  num_in;
   logic [llt_pkg::STAT_W-1:0]  status_in;
   logic [llt_pkg::PROD_W-1:0]  prod;

   // single read port: scan index while scanning, chosen slot in eval
   assign rd_addr  = cmd.eval ? sel_ff : cmd.idx;
   assign rd       = table_ff[rd_addr];
   assign hit      = (rd.key == key_ff);
   assign stat.hit = hit;

   // last empty slot wins, else smallest last-seen; slot zero seeds the pick
   assign take       = (cmd.idx == '0) || (rd.key == '0) || (rd.last_seen < pick_ls_ff);
   assign pick_in    = take ? cmd.idx : pick_ff;
   assign pick_ls_in = take ? rd.last_seen : pick_ls_ff;

   assign block_ext = {{(llt_pkg::TIME_W-llt_pkg::BLOCK_W){1'b0}}, cfg.block_ms};

   always_comb begin
      if (found_ff) begin
         ent = rd;
      end else begin
         ent = '0;
      end
      blocked = (ent.blocked_until != '0);
      diff    = ent.blocked_until - now_ff;
      locked  = blocked && (diff != '0) && !diff[llt_pkg::TIME_W-1];
      fc_base = blocked ? '0 : ent.fail_count;
      fc_inc  = (fc_base == llt_pkg::FAIL_SAT) ? fc_base : fc_base + 1'b1;

      wr.key           = key_ff;
      wr.last_seen     = now_ff;
      wr.fail_count    = '0;
      wr.blocked_until = '0;
      num_in           = '0;
      status_in        = llt_pkg::STATUS_GRANTED;

      if (locked) begin
         wr.fail_count    = ent.fail_count;
         wr.blocked_until = ent.blocked_until;
         num_in           = diff + llt_pkg::ROUND_UP;
         status_in        = llt_pkg::STATUS_LOCKED;
      end else if (!ok_ff) begin
         wr.fail_count = fc_inc;
         if (fc_inc >= cfg.max_failures) begin
            wr.blocked_until = now_ff + block_ext;
            num_in           = block_ext;
            status_in        = llt_pkg::STATUS_BAD_LOCKED;
         end else begin
            status_in = llt_pkg::STATUS_BAD;
         end
      end
   end

   assign prod = llt_pkg::PROD_W'(num_ff) * llt_pkg::PROD_W'(llt_pkg::RECIP_1000);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < llt_pkg::SLOT_COUNT; i++) begin
            table_ff[i] <= '0;
         end
      end else if (cmd.clear) begin
         for (int i = 0; i < llt_pkg::SLOT_COUNT; i++) begin
            table_ff[i] <= '0;
         end
      end else if (cmd.eval) begin
         table_ff[sel_ff] <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish | cmd.clear;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_word.client_key;
         now_ff <= req_word.now_ms;
         ok_ff  <= req_word.password_ok;
      end
      if (cmd.step) begin
         pick_ff    <= pick_in;
         pick_ls_ff <= pick_ls_in;
         sel_ff     <= hit ? cmd.idx : pick_in;
         found_ff   <= hit;
      end
      if (cmd.eval) begin
         num_ff    <= num_in;
         status_ff <= status_in;
      end
      if (cmd.clear) begin
         rsp_ff.status        <= llt_pkg::STATUS_CLEARED;
         rsp_ff.retry_after_s <= '0;
      end else if (cmd.finish) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.retry_after_s <= prod[llt_pkg::RECIP_SHIFT +: llt_pkg::RETRY_W];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

   `LLT_ASSERT_NOW(a_strobe_cause, strobe_ff,
      $past(cmd.finish) || $past(cmd.clear), "result word without a finish or clear")
   `LLT_ASSERT_NEXT(a_clear_word, cmd.clear,
      (rsp_ff.status == llt_pkg::STATUS_CLEARED) && (rsp_ff.retry_after_s == '0),
      "clear word not reported")
   `LLT_ASSERT_NOW(a_one_source, cmd.clear,
      !(cmd.step || cmd.eval || cmd.finish), "clear overlaps an attempt in flight")

endmodule

/* sv/login_lockout_table.sv */
// Top level of the login lockout table: configuration, sequencer and datapath.
//
// Usage:
//   Input channel: drive req_word and raise start; the word is taken at the
//   clock edge where start is high and busy is low. mode 0 is a login attempt,
//   mode 1 empties the whole slot table.
//   Result channel: rsp_strobe is high for one cycle with rsp_word (status,
//   retry_after_s); the receiver must take it in that cycle, there is no stall.
//   Config: APB-style, max_failures at 0x0, block_ms at 0x4, pready tied high;
//   write only while the block is idle.
// Sequence:
//   An attempt scans the slots one per cycle until the key matches or the last
//   slot is reached, then passes through an evaluation state and a state on the
//   /1000 multiplier before the strobe. busy stays high until the strobe cycle,
//   so the next word is taken only once the last attempt is through.
//   A clear word is done in the acceptance cycle; its strobe follows next cycle.
// Reset:
//   Synchronous reset empties all slots and loads max_failures 5, block_ms 60000.
module login_lockout_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  llt_pkg::req_type             req_word,
   output logic                         rsp_strobe,
   output llt_pkg::rsp_type             rsp_word,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [llt_pkg::CSR_AW-1:0]   paddr,
   input  logic [llt_pkg::CSR_DW-1:0]   pwdata,
   output logic [llt_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);

   llt_pkg::cfg_type      cfg;
   llt_pkg::ctl_cmd_type  cmd;
   llt_pkg::ctl_stat_type stat;

   llt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   llt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .mode  (req_word.mode),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   llt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cfg        (cfg),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

/* tb/sv/login_lockout_table_test.sv */
// Self-checking testbench for the login lockout table: directed and random words, APB setup.
`timescale 1ns / 100ps

module login_lockout_table_test;
   import llt_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int SHOW_LIMIT   = 10;
   localparam logic [TIME_W-1:0] MS_PER_SECOND = 32'd1000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_word = '0;
   logic               rsp_strobe;
   rsp_type            rsp_word;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [CSR_AW-1:0]  paddr = '0;
   logic [CSR_DW-1:0]  pwdata = '0;
   logic [CSR_DW-1:0]  prdata;
   logic               pready;

   login_lockout_table u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // shadow copy of the slot table and the registers
   logic [KEY_W-1:0]   slot_keys  [SLOT_COUNT];
   logic [TIME_W-1:0]  slot_seen  [SLOT_COUNT];
   logic [FAIL_W-1:0]  slot_fails [SLOT_COUNT];
   logic [TIME_W-1:0]  slot_until [SLOT_COUNT];
   logic [MAXF_W-1:0]  cfg_max_failures = MAXF_RESET;
   logic [BLOCK_W-1:0] cfg_block_ms = BLOCK_MS_RESET;

   req_type     pending_words[$];
   rsp_type     expected_verdicts[$];
   int unsigned sender_idle_pct = 0;
   int unsigned idle_cycles = 0;
   int unsigned errors = 0;
   int unsigned words_sent = 0;
   int unsigned status_seen [5] = '{default: 0};
   logic [TIME_W-1:0] wall_ms = '0;
   logic [KEY_W-1:0]  key_pool [6];

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   function automatic void wipe_slots();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_keys[i]  = '0;
         slot_seen[i]  = '0;
         slot_fails[i] = '0;
         slot_until[i] = '0;
      end
   endfunction

   // works out the verdict for one word and updates the shadow table
   function automatic rsp_type predict_verdict(req_type w);
      int unsigned pick;
      int unsigned s;
      bit found;
      logic [TIME_W-1:0] diff;
      logic [TIME_W-1:0] wait_s;
      rsp_type r;
      r = '0;
      if (w.mode == MODE_CLEAR) begin
         wipe_slots();
         r.status = STATUS_CLEARED;
         return r;
      end
      found = 1'b0;
      pick = 0;
      s = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!found) begin
            if (slot_keys[i] == w.client_key) begin
               s = i;
               found = 1'b1;
            end else if (slot_keys[i] == '0 || slot_seen[i] < slot_seen[pick]) begin
               pick = i;
            end
         end
      end
      if (!found) begin
         s = pick;
         slot_keys[s]  = w.client_key;
         slot_fails[s] = '0;
         slot_until[s] = '0;
      end
      slot_seen[s] = w.now_ms;
      if (slot_until[s] != '0) begin
         diff = slot_until[s] - w.now_ms;
         if (diff != '0 && !diff[TIME_W-1]) begin
            wait_s = (diff + MS_PER_SECOND - 1) / MS_PER_SECOND;
            r.status = STATUS_LOCKED;
            r.retry_after_s = wait_s[RETRY_W-1:0];
            return r;
         end
         slot_until[s] = '0;
         slot_fails[s] = '0;
      end
      if (!w.password_ok) begin
         if (slot_fails[s] != FAIL_SAT)
            slot_fails[s] = slot_fails[s] + 1'b1;
         if (slot_fails[s] >= cfg_max_failures) begin
            slot_until[s] = w.now_ms + {1'b0, cfg_block_ms};
            wait_s = {1'b0, cfg_block_ms} / MS_PER_SECOND;
            r.status = STATUS_BAD_LOCKED;
            r.retry_after_s = wait_s[RETRY_W-1:0];
         end else begin
            r.status = STATUS_BAD;
         end
      end else begin
         slot_fails[s] = '0;
         slot_until[s] = '0;
         r.status = STATUS_GRANTED;
      end
      return r;
   endfunction

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= SHOW_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // driver: one word at a time, random gaps between words
   always @(posedge clock) begin : drive
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_verdicts.push_back(predict_verdict(req_word));
            words_sent++;
         end
         if (!start || !busy) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_word <= pending_words.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: checks every strobed result against the oldest expectation
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe || (psel && penable))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_strobe) begin
            if (expected_verdicts.size() == 0) begin
               flag_error($sformatf("unexpected result: status %0d retry %0d",
                                    rsp_word.status, rsp_word.retry_after_s));
            end else begin
               want = expected_verdicts.pop_front();
               if (want.status <= STATUS_CLEARED)
                  status_seen[want.status]++;
               if (rsp_word.status !== want.status ||
                   rsp_word.retry_after_s !== want.retry_after_s)
                  flag_error($sformatf("mismatch: want status %0d retry %0d, got %0d retry %0d",
                                       want.status, want.retry_after_s,
                                       rsp_word.status, rsp_word.retry_after_s));
            end
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("login_lockout_table_test: errors");
      $finish;
   end

   task automatic csr_write(logic reg_sel, logic [CSR_DW-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == CSR_MAX_FAILURES)
         cfg_max_failures = value[MAXF_W-1:0];
      else
         cfg_block_ms = value[BLOCK_W-1:0];
   endtask

   // sender holds off until every result is back and the block is idle
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || expected_verdicts.size() != 0 || start || busy);
   endtask

   task automatic push_word(logic mode, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now_ms,
                            logic ok);
      req_type w;
      w.mode = mode;
      w.client_key = key;
      w.now_ms = now_ms;
      w.password_ok = ok;
      pending_words.push_back(w);
   endtask

   // mostly small forward steps, sometimes jumps, sometimes time runs backwards
   function automatic logic [TIME_W-1:0] next_time();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         wall_ms = wall_ms + $urandom_range(0, 3);
      else if (pick < 70)
         wall_ms = wall_ms + $urandom_range(0, 3000);
      else if (pick < 85)
         wall_ms = wall_ms + $urandom_range(0, cfg_block_ms);
      else if (pick < 92)
         wall_ms = $urandom;
      else
         wall_ms = wall_ms - $urandom_range(0, 2000);
      return wall_ms;
   endfunction

   task automatic queue_random(int unsigned count, int unsigned pool_n,
                               int unsigned rand_key_pct, int unsigned clear_pct,
                               int unsigned ok_pct);
      logic [KEY_W-1:0] key;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < rand_key_pct)
            key = $urandom;
         else
            key = key_pool[$urandom_range(0, pool_n - 1)];
         if ($urandom_range(0, 99) < clear_pct)
            push_word(MODE_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)));
         else
            push_word(MODE_ATTEMPT, key, next_time(), $urandom_range(0, 99) < ok_pct);
      end
   endtask

   task automatic run_phase(logic [MAXF_W-1:0] max_f, logic [BLOCK_W-1:0] blk,
                            int unsigned idle_pct, int unsigned count, int unsigned pool_n,
                            int unsigned rand_key_pct, int unsigned clear_pct,
                            int unsigned ok_pct);
      wait_idle();
      csr_write(CSR_MAX_FAILURES, CSR_DW'(max_f));
      csr_write(CSR_BLOCK_MS, CSR_DW'(blk));
      @(negedge clock);
      sender_idle_pct = idle_pct;
      queue_random(count, pool_n, rand_key_pct, clear_pct, ok_pct);
   endtask

   initial begin : stimulus
      logic [KEY_W-1:0] victim;
      wipe_slots();
      key_pool[0] = $urandom | 32'h1;
      key_pool[1] = '0;
      key_pool[2] = '1;
      key_pool[3] = $urandom | 32'h1;
      key_pool[4] = 32'h1;
      key_pool[5] = $urandom | 32'h1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      sender_idle_pct = 29;

      // directed part, reset register values
      victim = 32'h1234_5678;
      push_word(MODE_ATTEMPT, '0, '0, 1'b1);              // empty identity
      push_word(MODE_ATTEMPT, '1, '1, 1'b1);
      // five failures ending at a block that wraps to exactly zero
      for (int i = 0; i < 5; i++)
         push_word(MODE_ATTEMPT, victim, 32'hFFFF_15A0, 1'b0);
      push_word(MODE_ATTEMPT, victim, 32'hFFFF_15A1, 1'b0); // wrapped block reads as none
      push_word(MODE_ATTEMPT, victim, 32'hFFFF_15A2, 1'b0); // locked, long wait
      push_word(MODE_ATTEMPT, victim, 32'h0000_0000, 1'b1); // locked, one second left
      push_word(MODE_ATTEMPT, victim, 32'h0000_0001, 1'b1); // block just expired
      push_word(MODE_CLEAR, victim, 32'h5555_AAAA, 1'b0);
      // fill the table, then force evictions of the oldest slot
      push_word(MODE_ATTEMPT, 32'hA, 32'd100, 1'b0);
      push_word(MODE_ATTEMPT, 32'hB, 32'd50, 1'b0);
      push_word(MODE_ATTEMPT, 32'hC, 32'd200, 1'b1);
      push_word(MODE_ATTEMPT, 32'hD, 32'd300, 1'b0);
      push_word(MODE_ATTEMPT, 32'hE, 32'd400, 1'b0);
      push_word(MODE_ATTEMPT, 32'hB, 32'd500, 1'b0);
      push_word(MODE_ATTEMPT, 32'hA, 32'd600, 1'b0);
      push_word(MODE_ATTEMPT, '0, 32'hFFFF_FFFF, 1'b0);
      push_word(MODE_CLEAR, '1, '1, 1'b1);
      push_word(MODE_ATTEMPT, 32'hA, 32'd700, 1'b0);

      run_phase(8'd1, 31'd1, 29, 100, 6, 15, 2, 40);
      // pause the sender until everything is back, then continue
      wait_idle();
      queue_random(100, 6, 15, 2, 40);
      // one key hammered until the count tops out
      run_phase(8'd255, 31'd1500, 83, 300, 1, 0, 0, 0);
      run_phase(8'd3, 31'h7FFF_FFFF, 83, 200, 6, 10, 2, 30);
      run_phase(8'd4, 31'd5000, 0, 300, 6, 15, 3, 35);

      wait_idle();
      repeat (SLOT_COUNT + 4) @(posedge clock);
      @(negedge clock);
      if (expected_verdicts.size() != 0)
         flag_error($sformatf("%0d results never arrived", expected_verdicts.size()));
      $display("covered %0d words: %0d granted, %0d bad, %0d bad+locked, %0d locked, %0d clears",
               words_sent, status_seen[STATUS_GRANTED], status_seen[STATUS_BAD],
               status_seen[STATUS_BAD_LOCKED], status_seen[STATUS_LOCKED],
               status_seen[STATUS_CLEARED]);
      $display("register settings: reset, 1/1ms, 255/1.5s, 3/max, 4/5s; %0d errors", errors);
      if (errors == 0)
         $display("login_lockout_table_test: clean");
      else
         $display("login_lockout_table_test: errors");
      $finish;
   end

endmodule
